### rtl/lpc_pkg.sv
// shared types, codes and saturation helpers for the lagrange coefficient block
package lpc_pkg;

    localparam logic signed [63:0] Q_ONE   = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADIDX = 2'd1,
        ST_DUPX   = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_ONE, S_DUP_RD, S_DUP_CMP,
        S_PT_RD, S_PT_INIT, S_DIV_RD, S_DIV_GO, S_DIV_WAIT,
        S_POLY_INIT, S_FAC_RD, S_FAC_X, S_FAC_PRD, S_FAC_MUL, S_FAC_WAIT,
        S_ACC_RD, S_ACC_MUL, S_ACC_WAIT, S_EMIT_RD, S_EMIT
    } t_state;

    typedef struct packed {
        logic    wr_pt;
        logic    set_status;
        t_status status;
        logic    pt_init;
        logic    div_start;
        logic    div_take;
        logic    poly_init;
        logic    fac_xload;
        logic    fac_mul_start;
        logic    old_zero;
        logic    fac_write;
        logic    acc_mul_start;
        logic    acc_write;
        logic    acc_clr;
        logic    emit_acc;
    } t_dp_cmd;

    typedef struct packed {
        logic dup_eq;
        logic div_done;
        logic mul_done;
    } t_dp_sts;

    // sign and magnitude to int64 with clamping
    function automatic logic signed [63:0] sat_mag96(input logic neg, input logic [95:0] m);
        logic signed [63:0] res;
        if (!neg) begin
            res = (m[95:63] != '0) ? S64_MAX : $signed(m[63:0]);
        end else begin
            res = (m[95:63] != '0) ? S64_MIN : -$signed(m[63:0]);
        end
        return res;
    endfunction

    // clamp an exact 65-bit sum to int64
    function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
        logic signed [63:0] res;
        if (s[64] != s[63]) begin
            res = s[64] ? S64_MIN : S64_MAX;
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

endpackage

### rtl/lpc_in_if.sv
// request channel: point write or compute
interface lpc_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [7:0]         point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;

    modport source (output valid, op, point_index, x_value, y_value, input ready);
    modport sink   (input valid, op, point_index, x_value, y_value, output ready);
endinterface

### rtl/lpc_out_if.sv
// result channel: status and coefficients
interface lpc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         power;
    logic signed [63:0] coefficient;
    logic               last;

    modport source (output valid, status, power, coefficient, last, input ready);
    modport sink   (input valid, status, power, coefficient, last, output ready);
endinterface

### rtl/lpc_cfg_if.sv
// configuration write channel for point_count
interface lpc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/lpc_mul.sv
// q32.32 multiplier built from four 32x32 partial products
module lpc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import lpc_pkg::*;

    logic               r_busy;
    logic [2:0]         r_cnt;
    logic               r_done;
    logic [63:0]        r_am;
    logic [63:0]        r_bm;
    logic               r_neg;
    logic [63:0]        r_pp;
    logic [1:0]         r_psel;
    logic [127:0]       r_acc;
    logic signed [63:0] r_res;
    logic [31:0]        w_ah;
    logic [31:0]        w_bh;
    logic [127:0]       w_pp_sh;

    always_comb begin
        w_ah = r_cnt[1] ? r_am[63:32] : r_am[31:0];
        w_bh = (r_cnt[1:0] == 2'd1 || r_cnt[1:0] == 2'd3) ? r_bm[63:32] : r_bm[31:0];
        unique case (r_psel)
            2'd0:    w_pp_sh = {64'd0, r_pp};
            2'd3:    w_pp_sh = {r_pp, 64'd0};
            default: w_pp_sh = {32'd0, r_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_am  <= i_a[63] ? 64'(-i_a) : i_a;
            r_bm  <= i_b[63] ? 64'(-i_b) : i_b;
            r_neg <= i_a[63] != i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt < 3'd4) begin
                r_pp   <= w_ah * w_bh;
                r_psel <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + w_pp_sh;
            end
            if (r_cnt == 3'd5) begin
                r_res <= sat_mag96(r_neg, r_acc[127:32]);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

### rtl/lpc_div.sv
// bit-serial restoring divider: q32.32 by q17.16 giving q32.32
module lpc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_c,
    input  logic signed [32:0] i_d,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import lpc_pkg::*;

    localparam int NUM_W = 80;

    logic               r_busy;
    logic               r_done;
    logic [6:0]         r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_q;
    logic [32:0]        r_rem;
    logic [32:0]        r_dm;
    logic               r_neg;
    logic signed [63:0] r_res;
    logic [63:0]        w_cm;
    logic [33:0]        w_rsh;
    logic               w_ge;

    always_comb begin
        w_cm  = i_c[63] ? 64'(-i_c) : i_c;
        w_rsh = {r_rem, r_num[NUM_W-1]};
        w_ge  = w_rsh >= {1'b0, r_dm};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_d == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 7'(NUM_W);
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {w_cm, 16'd0};
            r_q   <= '0;
            r_rem <= '0;
            r_dm  <= i_d[32] ? 33'(-i_d) : i_d;
            r_neg <= i_c[63] != i_d[32];
            if (i_d == '0) begin
                r_res <= (i_c == '0) ? 64'sd0 : (i_c[63] ? S64_MIN : S64_MAX);
            end
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_res <= sat_mag96(r_neg, {16'd0, r_q});
            end else begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_rem <= w_ge ? 33'(w_rsh - {1'b0, r_dm}) : w_rsh[32:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

### rtl/lpc_dp.sv
// datapath: point stores, product polynomial, accumulators and arithmetic units
module lpc_dp #(
    parameter int MAX_POINTS_P = 16,
    parameter int IW = $clog2(MAX_POINTS_P)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpc_pkg::t_dp_cmd       i_cmd,
    input  logic [IW-1:0]          i_addr_a,
    input  logic [IW-1:0]          i_addr_b,
    input  logic [IW-1:0]          i_addr_k,
    input  logic [IW-1:0]          i_wr_idx,
    input  logic signed [31:0]     i_x,
    input  logic signed [31:0]     i_y,
    output lpc_pkg::t_dp_sts       o_sts,
    output logic [1:0]             o_status,
    output logic signed [63:0]     o_coef
);
    import lpc_pkg::*;

    logic signed [31:0] x_mem [MAX_POINTS_P];
    logic signed [31:0] y_mem [MAX_POINTS_P];
    logic signed [63:0] poly_mem [MAX_POINTS_P];
    logic signed [63:0] acc_mem [MAX_POINTS_P];
    logic [MAX_POINTS_P-1:0] r_vld;

    logic signed [31:0] r_xa;
    logic signed [31:0] r_ya;
    logic signed [31:0] r_xb;
    logic signed [31:0] r_xi;
    logic signed [63:0] r_c;
    logic signed [63:0] r_xj;
    logic signed [63:0] r_carry;
    logic signed [63:0] r_old;
    logic signed [63:0] r_poly_rd;
    logic signed [63:0] r_acc_rd;
    logic [1:0]         r_status;

    logic signed [63:0] w_old;
    logic signed [32:0] w_d;
    logic               w_mul_start;
    logic signed [63:0] w_mul_a;
    logic signed [63:0] w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_quot;
    logic               w_div_done;
    logic               w_mul_done;
    logic signed [63:0] w_accv;
    logic [IW-1:0]      w_poly_wa;

    always_comb begin
        w_old       = i_cmd.old_zero ? 64'sd0 : r_poly_rd;
        w_d         = {r_xi[31], r_xi} - {r_xb[31], r_xb};
        w_mul_start = i_cmd.fac_mul_start | i_cmd.acc_mul_start;
        w_mul_a     = i_cmd.fac_mul_start ? r_xj : r_poly_rd;
        w_mul_b     = i_cmd.fac_mul_start ? w_old : r_c;
        w_accv      = i_cmd.acc_clr ? 64'sd0 : r_acc_rd;
        w_poly_wa   = i_cmd.poly_init ? '0 : i_addr_k;
    end

    lpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_prod)
    );

    lpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_c     (r_c),
        .i_d     (w_d),
        .o_done  (w_div_done),
        .o_res   (w_quot)
    );

    // never-written slots read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr_pt) begin
            r_vld[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pt) begin
            x_mem[i_wr_idx] <= i_x;
            y_mem[i_wr_idx] <= i_y;
        end
        r_xa <= r_vld[i_addr_a] ? x_mem[i_addr_a] : 32'sd0;
        r_ya <= r_vld[i_addr_a] ? y_mem[i_addr_a] : 32'sd0;
        r_xb <= r_vld[i_addr_b] ? x_mem[i_addr_b] : 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.poly_init || i_cmd.fac_write) begin
            poly_mem[w_poly_wa] <= i_cmd.poly_init ? Q_ONE
                                 : sat65({r_carry[63], r_carry} - {w_prod[63], w_prod});
        end
        if (i_cmd.acc_write) begin
            acc_mem[i_addr_k] <= sat65({w_accv[63], w_accv} + {w_prod[63], w_prod});
        end
        r_poly_rd <= poly_mem[i_addr_k];
        r_acc_rd  <= acc_mem[i_addr_k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_init) begin
            r_xi <= r_xa;
            r_c  <= {{16{r_ya[31]}}, r_ya, 16'd0};
        end else if (i_cmd.div_take) begin
            r_c <= w_quot;
        end
        if (i_cmd.fac_xload) begin
            r_xj    <= {{16{r_xb[31]}}, r_xb, 16'd0};
            r_carry <= 64'sd0;
        end else if (i_cmd.fac_write) begin
            r_carry <= r_old;
        end
        if (i_cmd.fac_mul_start) begin
            r_old <= w_old;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    assign o_sts.dup_eq   = r_xa == r_xb;
    assign o_sts.div_done = w_div_done;
    assign o_sts.mul_done = w_mul_done;
    assign o_status       = r_status;
    assign o_coef         = i_cmd.emit_acc ? r_acc_rd : 64'sd0;
endmodule

### rtl/lpc_ctrl.sv
// sequencer: point loops, factor and accumulate steps, result handshake
module lpc_ctrl #(
    parameter int MAX_POINTS_P = 16,
    parameter int IW = $clog2(MAX_POINTS_P),
    parameter int CW = $clog2(MAX_POINTS_P + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_op,
    input  logic [7:0]       i_idx,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [3:0]       o_power,
    output logic             o_last,
    input  logic             i_cfg_valid,
    input  logic [4:0]       i_cfg_data,
    output lpc_pkg::t_dp_cmd o_cmd,
    input  lpc_pkg::t_dp_sts i_sts,
    output logic [IW-1:0]    o_addr_a,
    output logic [IW-1:0]    o_addr_b,
    output logic [IW-1:0]    o_addr_k
);
    import lpc_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_n, n_n;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_deg, n_deg;
    logic [4:0]    r_pc;
    logic [CW-1:0] w_nc;
    logic          w_k_last;
    logic          w_k_top;

    always_comb begin
        w_nc     = ({1'b0, r_pc} > 6'(MAX_POINTS_P)) ? CW'(MAX_POINTS_P) : CW'(r_pc);
        w_k_last = CW'(r_k) + CW'(1) == r_n;
        w_k_top  = {1'b0, r_k} == {1'b0, r_deg} + (IW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_deg   <= '0;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_k     <= n_k;
            r_deg   <= n_deg;
            if (i_cfg_valid) begin
                r_pc <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_k         = r_k;
        n_deg       = r_deg;
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_power     = 4'(r_k);
        o_last      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.set_status = 1'b1;
                    if (!i_op) begin
                        if (i_idx < 8'(MAX_POINTS_P)) begin
                            o_cmd.wr_pt = 1'b1;
                        end else begin
                            o_cmd.status = ST_BADIDX;
                        end
                        n_state = S_ONE;
                    end else begin
                        n_n = w_nc;
                        n_i = '0;
                        n_j = CW'(1);
                        priority if (w_nc == '0) begin
                            n_state = S_ONE;
                        end else if (w_nc == CW'(1)) begin
                            n_state = S_PT_RD;
                        end else begin
                            n_state = S_DUP_RD;
                        end
                    end
                end
            end
            S_ONE: begin
                o_out_valid = 1'b1;
                o_power     = '0;
                o_last      = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_DUP_RD: begin
                n_state = S_DUP_CMP;
            end
            S_DUP_CMP: begin
                n_state = S_DUP_RD;
                if (i_sts.dup_eq) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_DUPX;
                    n_state          = S_ONE;
                end else if (r_j + CW'(1) == r_n) begin
                    if (r_i + CW'(2) == r_n) begin
                        n_i     = '0;
                        n_state = S_PT_RD;
                    end else begin
                        n_i = r_i + CW'(1);
                        n_j = r_i + CW'(2);
                    end
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            S_PT_RD: begin
                n_state = S_PT_INIT;
            end
            S_PT_INIT: begin
                o_cmd.pt_init = 1'b1;
                n_j           = '0;
                n_state       = S_DIV_RD;
            end
            S_DIV_RD: begin
                priority if (r_j == r_n) begin
                    n_state = S_POLY_INIT;
                end else if (r_j == r_i) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_j            = r_j + CW'(1);
                    n_state        = S_DIV_RD;
                end
            end
            S_POLY_INIT: begin
                o_cmd.poly_init = 1'b1;
                n_deg           = '0;
                n_j             = '0;
                n_state         = S_FAC_RD;
            end
            S_FAC_RD: begin
                priority if (r_j == r_n) begin
                    n_k     = '0;
                    n_state = S_ACC_RD;
                end else if (r_j == r_i) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_state = S_FAC_X;
                end
            end
            S_FAC_X: begin
                o_cmd.fac_xload = 1'b1;
                n_k             = '0;
                n_state         = S_FAC_PRD;
            end
            S_FAC_PRD: begin
                n_state = S_FAC_MUL;
            end
            S_FAC_MUL: begin
                o_cmd.fac_mul_start = 1'b1;
                // the coefficient above the current degree is still zero
                o_cmd.old_zero      = r_k > r_deg;
                n_state             = S_FAC_WAIT;
            end
            S_FAC_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.fac_write = 1'b1;
                    if (w_k_top) begin
                        n_deg   = r_deg + IW'(1);
                        n_j     = r_j + CW'(1);
                        n_state = S_FAC_RD;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_FAC_PRD;
                    end
                end
            end
            S_ACC_RD: begin
                n_state = S_ACC_MUL;
            end
            S_ACC_MUL: begin
                o_cmd.acc_mul_start = 1'b1;
                n_state             = S_ACC_WAIT;
            end
            S_ACC_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.acc_write = 1'b1;
                    o_cmd.acc_clr   = r_i == '0;
                    if (w_k_last) begin
                        n_k = '0;
                        if (r_i + CW'(1) == r_n) begin
                            n_state = S_EMIT_RD;
                        end else begin
                            n_i     = r_i + CW'(1);
                            n_state = S_PT_RD;
                        end
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_ACC_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid    = 1'b1;
                o_cmd.emit_acc = 1'b1;
                o_last         = w_k_last;
                if (i_out_ready) begin
                    if (w_k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_addr_a = r_i[IW-1:0];
    assign o_addr_b = r_j[IW-1:0];
    assign o_addr_k = r_k;

    a_ready_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input taken while a result is pending");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.div_start && (o_cmd.fac_mul_start || o_cmd.acc_mul_start)))
        else $error("divider and multiplier started together");

    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_op) |=> (o_out_valid && o_last))
        else $error("point write not answered in the next cycle");

    a_dup_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUP_CMP && i_sts.dup_eq) |=> (r_state == S_ONE))
        else $error("duplicate x did not produce a single result");
endmodule

### rtl/lagrange_poly_coefficients.sv
// top level: lagrange interpolation polynomial coefficients over stored points
// point write: result shown in the cycle after the transaction; one transaction at a time
// compute of n points: n results, or a single result when n is zero or two x values match
// the time is set by the bit-serial divider (one run per division) and the multiplier
// built from four 32x32 partial products (one run per factor or accumulate step)
// reset clears the store valid bits (never-written points read as zero) and point_count
module lagrange_poly_coefficients #(
    parameter int MAX_POINTS_P = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lpc_in_if.sink   i_in,
    lpc_out_if.source o_out,
    lpc_cfg_if.sink  i_cfg
);
    import lpc_pkg::*;

    localparam int IW = $clog2(MAX_POINTS_P);
    localparam int CW = $clog2(MAX_POINTS_P + 1);

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [IW-1:0] w_addr_a;
    logic [IW-1:0] w_addr_b;
    logic [IW-1:0] w_addr_k;

    assign i_cfg.ready = 1'b1;

    lpc_ctrl #(
        .MAX_POINTS_P (MAX_POINTS_P),
        .IW           (IW),
        .CW           (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .i_idx       (i_in.point_index),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_power     (o_out.power),
        .o_last      (o_out.last),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .o_addr_a    (w_addr_a),
        .o_addr_b    (w_addr_b),
        .o_addr_k    (w_addr_k)
    );

    lpc_dp #(
        .MAX_POINTS_P (MAX_POINTS_P),
        .IW           (IW)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_addr_a (w_addr_a),
        .i_addr_b (w_addr_b),
        .i_addr_k (w_addr_k),
        .i_wr_idx (i_in.point_index[IW-1:0]),
        .i_x      (i_in.x_value),
        .i_y      (i_in.y_value),
        .o_sts    (w_sts),
        .o_status (o_out.status),
        .o_coef   (o_out.coefficient)
    );
endmodule
